@@ sv/vpp_pkg.sv @@
package vpp_pkg;

  // default fixed-point formats
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int COEF_FRAC_BITS_DEF  = 12;

  // field and datapath widths
  localparam int PT_W      = 32;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = 48;
  localparam int CLIP_W    = 50;
  localparam int NUM_W     = 51;
  localparam int SIZE_W    = 13;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_W     = 32;

  // queue between front and back
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0   = 3'd0,
    CFG_ROW1   = 3'd1,
    CFG_ROW2   = 3'd2,
    CFG_ROW3   = 3'd3,
    CFG_WIDTH  = 3'd4,
    CFG_HEIGHT = 3'd5
  } cfg_idx_t;

  typedef logic [3:0][CFG_W-1:0] matrix_t;

  // one classified vertex: numerators n = c + w, clip w, zero-w flag
  typedef struct packed {
    logic signed [NUM_W-1:0]  nx;
    logic signed [NUM_W-1:0]  ny;
    logic signed [CLIP_W-1:0] cw;
    logic                     wz;
  } vtx_t;

endpackage

@@ sv/vpp_front.sv @@
module vpp_front import vpp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_vld,
  input  logic signed [PT_W-1:0] px,
  input  logic signed [PT_W-1:0] py,
  input  logic signed [PT_W-1:0] pz,
  input  matrix_t                mat,
  output logic                   out_vld,
  output vtx_t                   out_vtx
);

  logic signed [PT_W-1:0]   pt [3];
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [CLIP_W-1:0] cterm [3];
  logic signed [CLIP_W-1:0] clip [3];
  logic v1, v2;

  assign pt[0] = px;
  assign pt[1] = py;
  assign pt[2] = pz;

  // valid bits, no stall: space is reserved before a request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1      <= in_vld;
      v2      <= v1;
      out_vld <= v2;
    end
  end

  // rows x, y and w of the matrix: products, then row sums
  for (genvar r = 0; r < 3; r++) begin : g_row
    localparam int ROW = (r == 2) ? 3 : r;
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk) begin
        prod[r][j] <= $signed(mat[ROW][COEF_W*j +: COEF_W]) * pt[j];
      end
    end
    always_ff @(posedge clk) begin
      cterm[r] <= CLIP_W'($signed(mat[ROW][COEF_W*3 +: COEF_W])) <<< COORD_FRAC_BITS;
      clip[r]  <= CLIP_W'(prod[r][0]) + CLIP_W'(prod[r][1]) + CLIP_W'(prod[r][2])
                  + cterm[r];
    end
  end

  // classify: numerators and zero w
  always_ff @(posedge clk) begin
    out_vtx.nx <= NUM_W'(clip[0]) + NUM_W'(clip[2]);
    out_vtx.ny <= NUM_W'(clip[1]) + NUM_W'(clip[2]);
    out_vtx.cw <= clip[2];
    out_vtx.wz <= (clip[2] == '0);
  end

endmodule

@@ sv/vpp_queue.sv @@
module vpp_queue import vpp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  vtx_t din,
  input  logic pop,
  output logic not_empty,
  output vtx_t dout
);

  vtx_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign dout      = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

@@ sv/vpp_back.sv @@
module vpp_back import vpp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_vld,
  input  vtx_t                    q_vtx,
  output logic                    q_pop,
  input  logic [SIZE_W-1:0]       width,
  input  logic [SIZE_W-1:0]       height,
  input  logic                    m_tready,
  output logic                    m_tvalid,
  output logic signed [PIX_W-1:0] pixel_x,
  output logic signed [PIX_W-1:0] pixel_y,
  output logic                    w_zero
);

  localparam int DEN_W = NUM_W;
  localparam int STEPS = PIX_W;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [PIX_W-1:0] low;
    logic [PIX_W-1:0] q;
    logic             ovf;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic             wz;
    logic [PIX_W-1:0] satx;
    logic [PIX_W-1:0] saty;
  } ctl_t;

  // one restoring step, next dividend bit taken from the top of low
  function automatic lane_t div_step(lane_t l, logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    logic           ge;
    lane_t          r;
    t       = {l.rem, l.low[PIX_W-1]};
    ge      = (t >= {1'b0, den});
    r       = l;
    r.rem   = ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
    r.low   = {l.low[PIX_W-2:0], 1'b0};
    r.q     = {l.q[PIX_W-2:0], ge};
    return r;
  endfunction

  // sign and saturation of a finished quotient
  function automatic logic [PIX_W-1:0] finish(lane_t l);
    logic             neg;
    logic [PIX_W-1:0] lim;
    logic [PIX_W-1:0] mag;
    neg = l.neg && (l.ovf || (l.q != '0));
    lim = neg ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
    mag = (l.ovf || (l.q > lim)) ? lim : l.q;
    return neg ? PIX_W'(-mag) : mag;
  endfunction

  function automatic logic [PIX_W-1:0] sat_of(logic signed [NUM_W-1:0] c);
    if (c[NUM_W-1]) return {1'b1, {(PIX_W-1){1'b0}}};
    if (c != '0)    return {1'b0, {(PIX_W-1){1'b1}}};
    return '0;
  endfunction

  logic adv;
  logic v0, v1;
  logic [NUM_W-1:0]  ax0, ay0;
  logic [CLIP_W-1:0] ad0;
  logic              negx0, negy0, wz0;
  logic [PIX_W-1:0]  satx0, saty0;
  logic [44:0]       xlo1, ylo1;
  logic [PIX_W-1:0]  xhi1, yhi1;
  logic [DEN_W-1:0]  den1;
  logic              negx1, negy1, wz1;
  logic [PIX_W-1:0]  satx1, saty1;
  logic [63:0]       xprod, yprod;
  logic [72:0]       xnum, ynum;
  lane_t             lx [STEPS+1];
  lane_t             ly [STEPS+1];
  ctl_t              cs [STEPS+1];
  logic              dv [STEPS+1];

  // whole back end moves when the output register is free or taken
  assign adv      = !m_tvalid || m_tready;
  assign q_pop    = adv && q_vld;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      dv[0]    <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v0       <= q_vld;
      v1       <= v0;
      dv[0]    <= v1;
      m_tvalid <= dv[STEPS];
    end
  end

  // magnitudes, result signs and zero-w saturation values
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ax0   <= q_vtx.nx[NUM_W-1] ? NUM_W'(-q_vtx.nx) : NUM_W'(q_vtx.nx);
      ay0   <= q_vtx.ny[NUM_W-1] ? NUM_W'(-q_vtx.ny) : NUM_W'(q_vtx.ny);
      ad0   <= q_vtx.cw[CLIP_W-1] ? CLIP_W'(-q_vtx.cw) : CLIP_W'(q_vtx.cw);
      negx0 <= q_vtx.nx[NUM_W-1] ^ q_vtx.cw[CLIP_W-1];
      negy0 <= q_vtx.ny[NUM_W-1] ^ q_vtx.cw[CLIP_W-1];
      wz0   <= q_vtx.wz;
      satx0 <= sat_of(q_vtx.nx);
      saty0 <= sat_of(q_vtx.ny);
    end
  end

  // scale by viewport size, split in two partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      xlo1  <= 45'(ax0[31:0]) * 45'(width);
      xhi1  <= 32'(ax0[NUM_W-1:32]) * 32'(width);
      ylo1  <= 45'(ay0[31:0]) * 45'(height);
      yhi1  <= 32'(ay0[NUM_W-1:32]) * 32'(height);
      den1  <= {ad0, 1'b0};
      negx1 <= negx0;
      negy1 <= negy0;
      wz1   <= wz0;
      satx1 <= satx0;
      saty1 <= saty0;
    end
  end

  // dividend with rounding term, overflow check, divider entry
  always_comb begin
    xprod = {xhi1, 32'd0} + 64'(xlo1);
    yprod = {yhi1, 32'd0} + 64'(ylo1);
    xnum  = {1'b0, xprod, 8'd0} + 73'(den1[DEN_W-1:1]);
    ynum  = {1'b0, yprod, 8'd0} + 73'(den1[DEN_W-1:1]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lx[0].rem  <= DEN_W'(xnum[72:32]);
      lx[0].low  <= xnum[31:0];
      lx[0].q    <= '0;
      lx[0].ovf  <= (DEN_W'(xnum[72:32]) >= den1);
      lx[0].neg  <= negx1;
      ly[0].rem  <= DEN_W'(ynum[72:32]);
      ly[0].low  <= ynum[31:0];
      ly[0].q    <= '0;
      ly[0].ovf  <= (DEN_W'(ynum[72:32]) >= den1);
      ly[0].neg  <= negy1;
      cs[0].den  <= den1;
      cs[0].wz   <= wz1;
      cs[0].satx <= satx1;
      cs[0].saty <= saty1;
    end
  end

  // divider pipeline, one quotient bit per stage for each lane
  for (genvar k = 0; k < STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        lx[k+1] <= div_step(lx[k], cs[k].den);
        ly[k+1] <= div_step(ly[k], cs[k].den);
        cs[k+1] <= cs[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_x <= cs[STEPS].wz ? cs[STEPS].satx : finish(lx[STEPS]);
      pixel_y <= cs[STEPS].wz ? cs[STEPS].saty : finish(ly[STEPS]);
      w_zero  <= cs[STEPS].wz;
    end
  end

endmodule

@@ sv/vertex_project_to_pixel.sv @@
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-------------------------------------------
// s_axis    | in        | s_tvalid/s_tready  | tdata: point_x, point_y, point_z (Q16.16)
// m_axis    | out       | m_tvalid/m_tready  | tdata: pixel_x, pixel_y (Q24.8); tuser: w_zero
// cfg       | in        | cfg_wr_en          | cfg_index, cfg_data
//
// one point per cycle unless stalled; 3 front stages (matrix products, row sums, classify),
// then the queue, 3 back stages, a 32-stage divider and the output register.
// rst is synchronous and restores the identity matrix and an 800x800 viewport.
// s_tready drops only when all 8 queue slots are reserved, by points in the front or queue;
// a stalled output holds the back end, the front keeps draining into the queue.
module vertex_project_to_pixel import vpp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [3*PT_W-1:0]    s_tdata,   // point_x, point_y, point_z
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [2*PIX_W-1:0]   m_tdata,   // pixel_x, pixel_y
  output logic                 m_tuser,   // w_zero
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  matrix_t           mat;
  logic [SIZE_W-1:0] width;
  logic [SIZE_W-1:0] height;
  logic              acc;
  logic              f_vld;
  vtx_t              f_vtx;
  logic              q_vld;
  vtx_t              q_vtx;
  logic              q_pop;
  logic [QCNT_W-1:0] used;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        mat[i] <= CFG_W'(1) << (COEF_FRAC_BITS + COEF_W * i);
      end
      width  <= SIZE_W'(800);
      height <= SIZE_W'(800);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROW0:   mat[0] <= cfg_data;
        CFG_ROW1:   mat[1] <= cfg_data;
        CFG_ROW2:   mat[2] <= cfg_data;
        CFG_ROW3:   mat[3] <= cfg_data;
        CFG_WIDTH:  width  <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT: height <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // queue slots reserved from request to pop
  assign s_tready = (used < QCNT_W'(QDEPTH));
  assign acc      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + QCNT_W'(acc) - QCNT_W'(q_pop);
    end
  end

  vpp_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (acc),
    .px      ($signed(s_tdata[PT_W-1:0])),
    .py      ($signed(s_tdata[2*PT_W-1:PT_W])),
    .pz      ($signed(s_tdata[3*PT_W-1:2*PT_W])),
    .mat     (mat),
    .out_vld (f_vld),
    .out_vtx (f_vtx)
  );

  vpp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_vld),
    .din       (f_vtx),
    .pop       (q_pop),
    .not_empty (q_vld),
    .dout      (q_vtx)
  );

  vpp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_vld    (q_vld),
    .q_vtx    (q_vtx),
    .q_pop    (q_pop),
    .width    (width),
    .height   (height),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y),
    .w_zero   (m_tuser)
  );

  assign m_tdata = {pixel_y, pixel_x};

endmodule

@@ sv/vpp_checker.sv @@
module vpp_checker import vpp_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [3*PT_W-1:0]    s_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [2*PIX_W-1:0]   m_tdata,
  input logic                 m_tuser,
  input logic                 cfg_wr_en,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // zero w only ever gives saturated or zero pixels
  a_wz_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
       m_tdata[31:0] == 32'h0) &&
      (m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000 ||
       m_tdata[63:32] == 32'h0))
    else $error("zero w result not saturated");

  // reset empties the pipeline and frees every slot
  a_rst_ready: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("not empty after reset");

  // m_tvalid stays low after reset beyond the point that a_rst_ready checks
  a_rst_latency: assert property (@(posedge clk) rst |=> ##1 !m_tvalid)
    else $error("result too early after reset");

endmodule

bind vertex_project_to_pixel vpp_checker u_chk (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import vpp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             w_zero;
  } pixel_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [3*PT_W-1:0]    s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [2*PIX_W-1:0]   m_tdata;
  logic                 m_tuser;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // local copy of the block configuration
  logic [CFG_W-1:0]  mat_row [4];
  logic [SIZE_W-1:0] view_w;
  logic [SIZE_W-1:0] view_h;

  pixel_t pending_pixels[$];
  int     mismatches;
  int     cycles;
  int     send_idle_pct;
  int     recv_stall_pct;

  vertex_project_to_pixel uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // dot product of one matrix row with (x, y, z, 1.0)
  function automatic logic signed [63:0] clip_value(logic [CFG_W-1:0] row,
                                                    logic [3*PT_W-1:0] pt);
    logic signed [63:0] acc;
    logic signed [63:0] coord;
    logic signed [15:0] coef;
    acc = 0;
    for (int j = 0; j < 4; j++) begin
      coef = row[16*j +: 16];
      if (j < 3) coord = $signed(pt[32*j +: 32]);
      else coord = 64'sd1 << COORD_FRAC_BITS_DEF;
      acc = acc + coef * coord;
    end
    return acc;
  endfunction

  // round(n*size*256 / (2*d)), ties away from zero, saturated to 32 bits
  function automatic logic [PIX_W-1:0] viewport_map(logic signed [63:0] n,
                                                    logic signed [63:0] d,
                                                    logic [SIZE_W-1:0] size);
    logic [127:0] an, ad, num, q;
    logic         neg;
    logic [127:0] lim;
    an = n < 0 ? 128'(-n) : 128'(n);
    ad = d < 0 ? 128'(-d) : 128'(d);
    num = an * (128'(size) << 8) + ad;
    q = num / (ad << 1);
    neg = ((n < 0) != (d < 0)) && (q != 0);
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    if (neg) q = -q;
    return q[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] sign_saturate(logic signed [63:0] c);
    if (c > 0) return 32'h7FFF_FFFF;
    if (c < 0) return 32'h8000_0000;
    return '0;
  endfunction

  function automatic pixel_t project_point(logic [3*PT_W-1:0] pt);
    pixel_t r;
    logic signed [63:0] cx, cy, cw;
    cx = clip_value(mat_row[0], pt);
    cy = clip_value(mat_row[1], pt);
    cw = clip_value(mat_row[3], pt);
    if (cw == 0) begin
      r.pixel_x = sign_saturate(cx);
      r.pixel_y = sign_saturate(cy);
      r.w_zero  = 1'b1;
    end else begin
      r.pixel_x = viewport_map(cx + cw, cw, view_w);
      r.pixel_y = viewport_map(cy + cw, cw, view_h);
      r.w_zero  = 1'b0;
    end
    return r;
  endfunction

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[PIX_W-1:0], m_tdata[2*PIX_W-1:PIX_W], m_tuser};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel error: exp x=%h y=%h wz=%b got x=%h y=%h wz=%b",
                     want.pixel_x, want.pixel_y, want.w_zero,
                     got.pixel_x, got.pixel_y, got.w_zero);
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("vertex_project_to_pixel: mismatch");
      $finish;
    end
  end

  // offer one point, with random sender gaps, until the request is taken
  task automatic send_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y, logic [PT_W-1:0] z);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    do @(posedge clk); while (!s_tready);
    pending_pixels.push_back(project_point({z, y, x}));
  endtask

  // stop sending and wait for all results
  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_WIDTH:  view_w = value[SIZE_W-1:0];
      CFG_HEIGHT: view_h = value[SIZE_W-1:0];
      default:    mat_row[idx[1:0]] = value;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_setup(logic [CFG_W-1:0] r0, logic [CFG_W-1:0] r1,
                             logic [CFG_W-1:0] r2, logic [CFG_W-1:0] r3,
                             logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    write_reg(CFG_ROW0, r0);
    write_reg(CFG_ROW1, r1);
    write_reg(CFG_ROW2, r2);
    write_reg(CFG_ROW3, r3);
    write_reg(CFG_WIDTH, 64'(w));
    write_reg(CFG_HEIGHT, 64'(h));
  endtask

  function automatic logic [15:0] rand_coef();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(16384)) - 8192);
  endfunction

  function automatic logic [CFG_W-1:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic logic [PT_W-1:0] rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
  endfunction

  // identity matrix and 800x800 after reset, field extremes
  task automatic test_reset_defaults;
    send_point(0, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA);
    drain();
  endtask

  // zero clip w: sign saturation of each pixel field
  task automatic test_zero_w;
    write_setup(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                64'h0000_1000_0000_0000, 64'h0, 13'd800, 13'd800);
    send_point(32'h0001_0000, 32'hFFFF_0000, 0);
    send_point(32'hFFFF_0000, 32'h0001_0000, 0);
    send_point(0, 0, 32'h1234_0000);
    drain();
    // w cancels exactly: w = z - 1.0
    write_reg(CFG_ROW3, {16'hF000, 16'h1000, 16'h0, 16'h0});
    send_point(32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
    send_point(32'h0002_0000, 32'h0003_0000, 32'h0001_0001);
    drain();
  endtask

  // viewport sizes at and beyond the nominal range
  task automatic test_viewport_sizes;
    write_setup(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                64'h0000_1000_0000_0000, 64'h1000_0000_0000_0000, 13'd0, 13'd8191);
    send_point(32'h0000_8000, 32'h0000_8000, 0);
    send_point(32'hFFFF_8000, 32'h7FFF_FFFF, 0);
    drain();
    write_setup(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                64'h0000_1000_0000_0000, 64'h1000_0000_0000_0000, 13'd1, 13'd4096);
    send_point(32'h0000_8000, 32'hFFFF_8000, 0);
    send_point(32'h0000_4000, 32'h0000_4000, 0);
    send_point(32'h0001_0000, 32'h0001_0000, 0);
    drain();
  endtask

  // extreme coefficients, overflow saturation
  task automatic test_extreme_coefs;
    write_setup({4{16'h7FFF}}, {4{16'h8000}}, {4{16'h8000}}, {16'h0001, 16'h0, 16'h0, 16'h0},
                13'd4096, 13'd4096);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();
    write_reg(CFG_ROW3, {4{16'h8000}});
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_point(32'h1234_5678, 32'h8765_4321, 32'h0F0F_F0F0);
    drain();
  endtask

  // random settings and points under one idling pattern
  task automatic test_random(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int s = 0; s < 2; s++) begin
      write_setup(rand_row(), rand_row(), rand_row(),
                  ($urandom_range(7) == 0) ? 64'h0 : rand_row(),
                  13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)));
      for (int i = 0; i < count; i++) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_ROW0;
    cfg_data       = '0;
    mismatches     = 0;
    cycles         = 0;
    send_idle_pct  = 10;
    recv_stall_pct = 87;
    mat_row[0] = 64'h0000_0000_0000_1000;
    mat_row[1] = 64'h0000_0000_1000_0000;
    mat_row[2] = 64'h0000_1000_0000_0000;
    mat_row[3] = 64'h1000_0000_0000_0000;
    view_w = 13'd800;
    view_h = 13'd800;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_zero_w();
    test_viewport_sizes();
    test_extreme_coefs();
    test_random(10, 87, 67);
    test_random(87, 10, 67);
    test_random(0, 0, 67);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("vertex_project_to_pixel: match");
    else $display("vertex_project_to_pixel: mismatch");
    $finish;
  end

endmodule
